>>> design/touch_gesture_classifier_top_macros.svh
// assertion macros used by the touch gesture classifier queue
`ifndef TOUCH_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgc assertion failed");

// next-cycle implication, checked outside reset
`define TGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgc assertion failed");

`endif

>>> design/tgc_pkg.sv
// types, codes and helpers shared by the touch gesture classifier
`timescale 1ns / 1ps

package tgc_pkg;

    // input commands
    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_MOVE    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_POLL    = 2'd3;

    // gesture codes
    localparam logic [2:0] GEST_TAP   = 3'd0;
    localparam logic [2:0] GEST_LONG  = 3'd1;
    localparam logic [2:0] GEST_LEFT  = 3'd2;
    localparam logic [2:0] GEST_RIGHT = 3'd3;
    localparam logic [2:0] GEST_UP    = 3'd4;
    localparam logic [2:0] GEST_DOWN  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_TAP_DIST   = 3'd0;
    localparam logic [2:0] CFG_TAP_TIME   = 3'd1;
    localparam logic [2:0] CFG_SWIPE_DIST = 3'd2;
    localparam logic [2:0] CFG_LONG_TIME  = 3'd3;
    localparam logic [2:0] CFG_LONG_DIST  = 3'd4;

    // configuration reset values
    localparam logic [21:0] RST_TAP_DIST   = 22'd400;
    localparam logic [15:0] RST_TAP_TIME   = 16'd500;
    localparam logic [21:0] RST_SWIPE_DIST = 22'd1600;
    localparam logic [15:0] RST_LONG_TIME  = 16'd800;
    localparam logic [21:0] RST_LONG_DIST  = 22'd400;

    typedef struct packed {
        logic [21:0] tap_max_dist_sq;
        logic [15:0] tap_max_time_ms;
        logic [21:0] swipe_min_dist_sq;
        logic [15:0] long_press_ms;
        logic [21:0] long_press_dist_sq;
    } t_cfg;

    // work handed from the front to the back
    typedef struct packed {
        logic        is_long;
        logic [9:0]  mag_x;
        logic [9:0]  mag_y;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] held;
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
    } t_job;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_qstat;

    // square of a 10-bit magnitude
    function automatic logic [19:0] sq10(input logic [9:0] a);
        return 20'(a) * 20'(a);
    endfunction

    // difference a - b of two coordinates as sign and magnitude
    function automatic logic [10:0] sdiff10(input logic [9:0] a, input logic [9:0] b);
        logic [10:0] d;
        logic [10:0] m;
        d = {1'b0, a} - {1'b0, b};
        m = d[10] ? (11'd0 - d) : d;
        return {d[10], m[9:0]};
    endfunction

endpackage

>>> design/tgc_front.sv
// front end: touch state tracking and long-press decision, issues work to the queue
`timescale 1ns / 1ps

module tgc_front
    import tgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [9:0]  i_pos_x,
    input  logic [9:0]  i_pos_y,
    input  logic [31:0] i_time_ms,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_active;
    logic        r_fired;
    logic [9:0]  r_start_x;
    logic [9:0]  r_start_y;
    logic [31:0] r_press_time;
    logic [20:0] r_drift_sq;

    logic        w_accept;
    logic [31:0] w_held;
    logic [10:0] w_dx;
    logic [10:0] w_dy;
    logic [20:0] w_new_drift;
    logic        w_long_hit;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;

    // geometry against the start point
    assign w_held      = i_time_ms - r_press_time;
    assign w_dx        = sdiff10(i_pos_x, r_start_x);
    assign w_dy        = sdiff10(i_pos_y, r_start_y);
    assign w_new_drift = 21'(sq10(w_dx[9:0])) + 21'(sq10(w_dy[9:0]));

    // long press condition on poll
    assign w_long_hit = r_active && !r_fired
                        && (w_held >= {16'd0, i_cfg.long_press_ms})
                        && ({1'b0, r_drift_sq} < i_cfg.long_press_dist_sq);

    // work item toward the back end
    always_comb begin
        o_push         = 1'b0;
        o_job.is_long  = (i_cmd == CMD_POLL);
        o_job.mag_x    = w_dx[9:0];
        o_job.mag_y    = w_dy[9:0];
        o_job.neg_x    = w_dx[10];
        o_job.neg_y    = w_dy[10];
        o_job.held     = w_held;
        o_job.origin_x = r_start_x;
        o_job.origin_y = r_start_y;
        if (w_accept) begin
            unique case (i_cmd)
                CMD_RELEASE: o_push = r_active && !r_fired;
                CMD_POLL:    o_push = w_long_hit;
                default:     o_push = 1'b0;
            endcase
        end
    end

    // touch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fired  <= 1'b0;
        end else if (w_accept) begin
            unique case (i_cmd)
                CMD_PRESS: begin
                    r_active <= 1'b1;
                    r_fired  <= 1'b0;
                end
                CMD_RELEASE: begin
                    r_active <= 1'b0;
                end
                CMD_POLL: begin
                    if (w_long_hit) begin
                        r_fired <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // start point, press time and drift of the held pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_press_time <= '0;
            r_drift_sq   <= '0;
        end else if (w_accept) begin
            if (i_cmd == CMD_PRESS) begin
                r_start_x    <= i_pos_x;
                r_start_y    <= i_pos_y;
                r_press_time <= i_time_ms;
                r_drift_sq   <= '0;
            end else if (i_cmd == CMD_MOVE && r_active) begin
                r_drift_sq <= w_new_drift;
            end
        end
    end

endmodule

>>> design/tgc_queue.sv
// small register queue between the front and back ends
`timescale 1ns / 1ps

`include "touch_gesture_classifier_top_macros.svh"

module tgc_queue
    import tgc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_job            = r_mem[r_rd_ptr];
    assign o_qstat.full     = (r_count == CW'(DEPTH));
    assign o_qstat.nonempty = (r_count != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `TGC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `TGC_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `TGC_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1))

endmodule

>>> design/tgc_back.sv
// back end: squares, release classification and output register
`timescale 1ns / 1ps

module tgc_back
    import tgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_qstat      i_qstat,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_gesture,
    output logic [9:0]  o_origin_x,
    output logic [9:0]  o_origin_y
);

    typedef struct packed {
        logic        is_long;
        logic [19:0] sq_x;
        logic [19:0] sq_y;
        logic        x_wins;
        logic        neg_x;
        logic        neg_y;
        logic        held_short;
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
    } t_s1;

    logic        r_s1_valid;
    t_s1         r_s1;
    logic        r_out_valid;
    logic [2:0]  r_gesture;
    logic [9:0]  r_origin_x;
    logic [9:0]  r_origin_y;

    logic        w_out_free;
    logic        w_s1_load;
    logic [20:0] w_d2;
    logic        w_hit;
    logic [2:0]  n_gesture;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_s1_load  = !r_s1_valid || w_out_free;
    assign o_pop      = i_qstat.nonempty && w_s1_load;

    // stage one: squares and compares from the queue head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1.is_long    <= i_job.is_long;
            r_s1.sq_x       <= sq10(i_job.mag_x);
            r_s1.sq_y       <= sq10(i_job.mag_y);
            r_s1.x_wins     <= (i_job.mag_x >= i_job.mag_y);
            r_s1.neg_x      <= i_job.neg_x;
            r_s1.neg_y      <= i_job.neg_y;
            r_s1.held_short <= (i_job.held < {16'd0, i_cfg.tap_max_time_ms});
            r_s1.origin_x   <= i_job.origin_x;
            r_s1.origin_y   <= i_job.origin_y;
        end
    end

    // stage two: distance and gesture decision
    assign w_d2 = 21'(r_s1.sq_x) + 21'(r_s1.sq_y);

    always_comb begin
        w_hit     = 1'b1;
        n_gesture = GEST_TAP;
        if (r_s1.is_long) begin
            n_gesture = GEST_LONG;
        end else if ({1'b0, w_d2} >= i_cfg.swipe_min_dist_sq) begin
            if (r_s1.x_wins) begin
                n_gesture = r_s1.neg_x ? GEST_LEFT : GEST_RIGHT;
            end else begin
                n_gesture = r_s1.neg_y ? GEST_UP : GEST_DOWN;
            end
        end else if (({1'b0, w_d2} < i_cfg.tap_max_dist_sq) && r_s1.held_short) begin
            n_gesture = GEST_TAP;
        end else begin
            w_hit = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid && w_hit) begin
            r_gesture  <= n_gesture;
            r_origin_x <= r_s1.origin_x;
            r_origin_y <= r_s1.origin_y;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_gesture  = r_gesture;
    assign o_origin_x = r_origin_x;
    assign o_origin_y = r_origin_y;

endmodule

>>> design/touch_gesture_classifier_top.sv
// Touch gesture classifier: takes one touch item (press, move, release, poll with a
// millisecond timestamp) per clock and reports tap, long press and the four swipes,
// each with the point where the touch started. The front end updates the touch state
// in the cycle an item is taken, so items may follow each other in every cycle. A
// gesture item passes through the queue, the stage-one register and the output
// register before it is valid on the output stream; the queue between front and
// back holds QUEUE_DEPTH pending gestures, and the input stalls only when that
// queue is full. Configuration must be written through the register port only
// while no gesture is pending; the block itself does not enforce this.
`timescale 1ns / 1ps

module touch_gesture_classifier_top
    import tgc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [21:0] i_cfg_data,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // cmd[1:0], pos_x[11:2], pos_y[21:12], time_ms[53:22]
    // gesture items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // gesture[2:0], origin_x[12:3], origin_y[22:13]
);

    t_cfg       r_cfg;
    t_qstat     w_qstat;
    logic       w_push;
    logic       w_pop;
    t_job       w_job_in;
    t_job       w_job_out;
    logic [2:0] w_gesture;
    logic [9:0] w_origin_x;
    logic [9:0] w_origin_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_max_dist_sq    <= RST_TAP_DIST;
            r_cfg.tap_max_time_ms    <= RST_TAP_TIME;
            r_cfg.swipe_min_dist_sq  <= RST_SWIPE_DIST;
            r_cfg.long_press_ms      <= RST_LONG_TIME;
            r_cfg.long_press_dist_sq <= RST_LONG_DIST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TAP_DIST:   r_cfg.tap_max_dist_sq    <= i_cfg_data;
                CFG_TAP_TIME:   r_cfg.tap_max_time_ms    <= i_cfg_data[15:0];
                CFG_SWIPE_DIST: r_cfg.swipe_min_dist_sq  <= i_cfg_data;
                CFG_LONG_TIME:  r_cfg.long_press_ms      <= i_cfg_data[15:0];
                CFG_LONG_DIST:  r_cfg.long_press_dist_sq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tgc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_cmd     (i_s_tdata[1:0]),
        .i_pos_x   (i_s_tdata[11:2]),
        .i_pos_y   (i_s_tdata[21:12]),
        .i_time_ms (i_s_tdata[53:22]),
        .i_qstat   (w_qstat),
        .o_push    (w_push),
        .o_job     (w_job_in)
    );

    tgc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_qstat (w_qstat)
    );

    tgc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_qstat    (w_qstat),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_gesture  (w_gesture),
        .o_origin_x (w_origin_x),
        .o_origin_y (w_origin_y)
    );

    assign o_m_tdata = {1'b0, w_origin_y, w_origin_x, w_gesture};

endmodule

>>> dv/testbench.sv
// testbench for the touch gesture classifier: predicted gestures checked against the output stream
`timescale 1ns / 1ps

module testbench;
    import tgc_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 238;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [31:0] time_ms;
        logic [9:0]  pos_y;
        logic [9:0]  pos_x;
        logic [1:0]  cmd;
    } t_touch;

    // gesture item, last field in the lowest bits
    typedef struct packed {
        logic [9:0] origin_y;
        logic [9:0] origin_x;
        logic [2:0] gesture;
    } t_gesture;

    // touch state tracker and queue of gestures still to come
    class gesture_scoreboard;
        t_cfg       cfg;
        bit         touching;
        bit         long_done;
        logic [9:0] start_x, start_y, last_x, last_y;
        logic [31:0] press_ms;
        t_gesture   expected_gestures[$];
        int         errors;
        int         checked;
        int         per_kind[6];

        function new();
            cfg = '{RST_TAP_DIST, RST_TAP_TIME, RST_SWIPE_DIST, RST_LONG_TIME, RST_LONG_DIST};
            touching  = 1'b0;
            long_done = 1'b0;
            start_x   = '0;
            start_y   = '0;
            last_x    = '0;
            last_y    = '0;
            press_ms  = '0;
        endfunction

        // squared distance between two points, with axis magnitudes and signs
        function logic [21:0] span_sq(input logic [9:0] ax, input logic [9:0] ay,
                                      input logic [9:0] bx, input logic [9:0] by,
                                      output int mx, output int my,
                                      output bit negx, output bit negy);
            int dx;
            int dy;
            dx   = int'(ax) - int'(bx);
            dy   = int'(ay) - int'(by);
            negx = dx < 0;
            negy = dy < 0;
            mx   = negx ? -dx : dx;
            my   = negy ? -dy : dy;
            return 22'(mx * mx + my * my);
        endfunction

        // update the touch state for one accepted item, queue any gesture it causes
        function void take_touch(t_touch t);
            logic [31:0] held;
            logic [21:0] d2;
            int          mx, my;
            bit          nx, ny;
            t_gesture    g;
            held       = t.time_ms - press_ms;
            g.origin_x = start_x;
            g.origin_y = start_y;
            g.gesture  = GEST_TAP;
            case (t.cmd)
                CMD_PRESS: begin
                    touching  = 1'b1;
                    long_done = 1'b0;
                    start_x   = t.pos_x;
                    start_y   = t.pos_y;
                    last_x    = t.pos_x;
                    last_y    = t.pos_y;
                    press_ms  = t.time_ms;
                end
                CMD_MOVE: begin
                    if (touching) begin
                        last_x = t.pos_x;
                        last_y = t.pos_y;
                    end
                end
                CMD_RELEASE: begin
                    if (touching) begin
                        touching = 1'b0;
                        if (!long_done) begin
                            d2 = span_sq(t.pos_x, t.pos_y, start_x, start_y, mx, my, nx, ny);
                            if (d2 >= cfg.swipe_min_dist_sq) begin
                                // dominant axis wins, ties go horizontal
                                if (mx >= my)
                                    g.gesture = nx ? GEST_LEFT : GEST_RIGHT;
                                else
                                    g.gesture = ny ? GEST_UP : GEST_DOWN;
                                expected_gestures.push_back(g);
                            end else if (d2 < cfg.tap_max_dist_sq &&
                                         held < 32'(cfg.tap_max_time_ms)) begin
                                expected_gestures.push_back(g);
                            end
                        end
                    end
                end
                default: begin
                    // poll: long press fires once per touch
                    if (touching && !long_done) begin
                        d2 = span_sq(last_x, last_y, start_x, start_y, mx, my, nx, ny);
                        if (held >= 32'(cfg.long_press_ms) && d2 < cfg.long_press_dist_sq) begin
                            long_done = 1'b1;
                            g.gesture = GEST_LONG;
                            expected_gestures.push_back(g);
                        end
                    end
                end
            endcase
        endfunction

        // compare one gesture from the block with the oldest one predicted
        function void check_gesture(t_gesture got);
            t_gesture want;
            if (expected_gestures.size() == 0) begin
                errors++;
                $display("%0t: unexpected gesture %0d origin (%0d,%0d), none expected",
                         $time, got.gesture, got.origin_x, got.origin_y);
            end else begin
                want = expected_gestures.pop_front();
                checked++;
                if (got.gesture !== want.gesture || got.origin_x !== want.origin_x ||
                    got.origin_y !== want.origin_y) begin
                    errors++;
                    $display("%0t: expected gesture %0d origin (%0d,%0d), actual %0d (%0d,%0d)",
                             $time, want.gesture, want.origin_x, want.origin_y,
                             got.gesture, got.origin_x, got.origin_y);
                end else begin
                    per_kind[want.gesture]++;
                end
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [2:0]  cfg_idx  = '0;
    logic [21:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    gesture_scoreboard sb;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          sent_items     = 0;
    logic [31:0] now_ms;

    touch_gesture_classifier_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    // watchdog
    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // receiver backpressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // accepted items on both sides
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.take_touch(t_touch'(s_tdata[53:0]));
            if (m_tvalid && m_tready)
                sb.check_gesture(t_gesture'(m_tdata[22:0]));
        end
    end

    function automatic logic [9:0] clamp10(input int v);
        return (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : 10'(v);
    endfunction

    // random offset in [-m, m]
    function automatic int signed_mag(input int m);
        int v;
        v = int'($urandom_range(0, m));
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    // present one item, with random gaps before it, and wait for the handshake
    task automatic push_touch(input logic [1:0] cmd, input logic [9:0] x,
                              input logic [9:0] y, input logic [31:0] t);
        t_touch it;
        it.cmd     = cmd;
        it.pos_x   = x;
        it.pos_y   = y;
        it.time_ms = t;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_items++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [21:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // stop sending, let the last item reach the scoreboard, drain all gestures,
    // then let the pipeline settle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_gestures.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // stimulus
    initial begin
        t_cfg        c;
        int          sx, sy, ex, ey, r, rx, ry, k, dr, thr, tmp;
        bit          wide_hold;
        logic [31:0] t0, hold, tm;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases at reset settings
        // nothing held: release, move and poll are ignored
        push_touch(CMD_RELEASE, 10'd5, 10'd5, 32'd10);
        push_touch(CMD_MOVE, 10'd7, 10'd7, 32'd20);
        push_touch(CMD_POLL, 10'd0, 10'd0, 32'd5000);
        // tap at the low corner
        push_touch(CMD_PRESS, 10'd0, 10'd0, 32'd100);
        push_touch(CMD_RELEASE, 10'd0, 10'd0, 32'd150);
        // long press right at the time limit, fires once, silent release
        push_touch(CMD_PRESS, 10'd1023, 10'd1023, 32'd1000);
        push_touch(CMD_MOVE, 10'd1023, 10'd1023, 32'd1100);
        push_touch(CMD_POLL, 10'd0, 10'd0, 32'd1800);
        push_touch(CMD_POLL, 10'd1023, 10'd1023, 32'd1900);
        push_touch(CMD_RELEASE, 10'd1023, 10'd1023, 32'd2000);
        // swipes left, up, down
        push_touch(CMD_PRESS, 10'd500, 10'd500, 32'd3000);
        push_touch(CMD_RELEASE, 10'd400, 10'd500, 32'd3100);
        push_touch(CMD_PRESS, 10'd500, 10'd500, 32'd3200);
        push_touch(CMD_RELEASE, 10'd500, 10'd400, 32'd3300);
        push_touch(CMD_PRESS, 10'd500, 10'd500, 32'd3400);
        push_touch(CMD_RELEASE, 10'd500, 10'd600, 32'd3500);
        // diagonal tie goes horizontal: right
        push_touch(CMD_PRESS, 10'd500, 10'd500, 32'd3600);
        push_touch(CMD_RELEASE, 10'd540, 10'd540, 32'd3700);
        // press while held restarts the touch
        push_touch(CMD_PRESS, 10'd10, 10'd10, 32'd4000);
        push_touch(CMD_PRESS, 10'd20, 10'd20, 32'd4005);
        push_touch(CMD_RELEASE, 10'd21, 10'd20, 32'd4010);
        // hold time across timestamp wrap
        push_touch(CMD_PRESS, 10'd3, 10'd4, 32'hFFFF_FFF0);
        push_touch(CMD_RELEASE, 10'd3, 10'd4, 32'h0000_0010);
        // drift too large blocks the long press
        push_touch(CMD_PRESS, 10'd100, 10'd100, 32'd6000);
        push_touch(CMD_MOVE, 10'd150, 10'd100, 32'd6100);
        push_touch(CMD_POLL, 10'd0, 10'd0, 32'd7000);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // idling pattern of this phase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase

            // new register settings while the block is idle
            if (ph > 0) begin
                if (ph == 1) begin
                    c = '0;
                end else if (ph == 2) begin
                    c = '1;
                end else if (ph == 5) begin
                    c.tap_max_dist_sq    = 22'($urandom());
                    c.tap_max_time_ms    = 16'($urandom());
                    c.swipe_min_dist_sq  = 22'($urandom());
                    c.long_press_ms      = 16'($urandom());
                    c.long_press_dist_sq = 22'($urandom());
                end else begin
                    c.tap_max_dist_sq    = 22'($urandom_range(0, 3000));
                    c.tap_max_time_ms    = 16'($urandom_range(0, 1500));
                    c.swipe_min_dist_sq  = 22'($urandom_range(0, 6000));
                    c.long_press_ms      = 16'($urandom_range(0, 2500));
                    c.long_press_dist_sq = 22'($urandom_range(0, 3000));
                end
                settle();
                write_reg(CFG_TAP_DIST, c.tap_max_dist_sq);
                write_reg(CFG_TAP_TIME, 22'(c.tap_max_time_ms));
                write_reg(CFG_SWIPE_DIST, c.swipe_min_dist_sq);
                write_reg(CFG_LONG_TIME, 22'(c.long_press_ms));
                write_reg(CFG_LONG_DIST, c.long_press_dist_sq);
                cfg_we <= 1'b0;
                sb.cfg = c;
            end

            now_ms = $urandom();
            while (sent_items < (ph + 1) * ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any command, any position, often a wild timestamp
                    tm = $urandom_range(0, 1) ? $urandom() : now_ms + $urandom_range(0, 2000);
                    push_touch(2'($urandom_range(0, 3)), 10'($urandom()), 10'($urandom()), tm);
                end else begin
                    // one touch: press, moves and polls, release
                    sx = int'($urandom_range(0, 1023));
                    sy = int'($urandom_range(0, 1023));
                    t0 = now_ms;

                    // hold time near a limit, short, or anything at all
                    wide_hold = 1'b0;
                    case ($urandom_range(0, 5))
                        0: thr = int'(sb.cfg.tap_max_time_ms);
                        1: thr = int'(sb.cfg.long_press_ms);
                        2: thr = int'($urandom_range(0, 2000));
                        3: begin thr = 0; wide_hold = 1'b1; end
                        default: thr = int'($urandom_range(0, 150));
                    endcase
                    thr = thr + int'($urandom_range(0, 6)) - 3;
                    hold = wide_hold ? $urandom() : ((thr < 0) ? 32'd0 : 32'(thr));

                    // release distance near a limit, zero, small or anything
                    case ($urandom_range(0, 4))
                        0: r = $rtoi($sqrt(real'(sb.cfg.tap_max_dist_sq)));
                        1: r = $rtoi($sqrt(real'(sb.cfg.swipe_min_dist_sq)));
                        2: r = 0;
                        3: r = int'($urandom_range(0, 1447));
                        default: r = int'($urandom_range(0, 60));
                    endcase
                    r = r + int'($urandom_range(0, 2)) - 1;
                    if (r < 0) r = 0;
                    if (r > 1447) r = 1447;
                    rx = int'($urandom_range(0, r));
                    ry = $rtoi($sqrt(real'(r * r - rx * rx)));
                    if ($urandom_range(0, 7) == 0) ry = rx;
                    if ($urandom_range(0, 1)) begin
                        tmp = rx;
                        rx  = ry;
                        ry  = tmp;
                    end
                    ex = sx + ($urandom_range(0, 1) ? rx : -rx);
                    ey = sy + ($urandom_range(0, 1) ? ry : -ry);

                    push_touch(CMD_PRESS, 10'(sx), 10'(sy), t0);

                    // drift around the long press limit
                    dr = $rtoi($sqrt(real'(sb.cfg.long_press_dist_sq))) + 2;
                    if (dr > 1023) dr = 1023;
                    k = int'($urandom_range(0, 4));
                    for (int i = 1; i <= k; i++) begin
                        tm = t0 + 32'((64'(hold) * i) / (k + 1));
                        if ($urandom_range(0, 1))
                            push_touch(CMD_MOVE, clamp10(sx + signed_mag(dr)),
                                       clamp10(sy + signed_mag(dr)), tm);
                        else
                            push_touch(CMD_POLL, 10'($urandom()), 10'($urandom()), tm);
                    end
                    if ($urandom_range(0, 2) == 0)
                        push_touch(CMD_POLL, 10'($urandom()), 10'($urandom()), t0 + hold);

                    // usually one release, sometimes none or two
                    case ($urandom_range(0, 9))
                        0: ;
                        1: begin
                            push_touch(CMD_RELEASE, clamp10(ex), clamp10(ey), t0 + hold);
                            push_touch(CMD_RELEASE, clamp10(ex), clamp10(ey), t0 + hold + 1);
                        end
                        default: push_touch(CMD_RELEASE, clamp10(ex), clamp10(ey), t0 + hold);
                    endcase
                    now_ms = t0 + hold + $urandom_range(1, 3000);
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);

        $display("run: %0d touch items over %0d register settings, %0d gestures compared",
                 sent_items, NUM_PHASES, sb.checked);
        $display("taps %0d, long presses %0d, swipes left %0d right %0d up %0d down %0d",
                 sb.per_kind[GEST_TAP], sb.per_kind[GEST_LONG], sb.per_kind[GEST_LEFT],
                 sb.per_kind[GEST_RIGHT], sb.per_kind[GEST_UP], sb.per_kind[GEST_DOWN]);
        if (sb.errors == 0 && sb.expected_gestures.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
